/* hdl/itp_pkg.sv */
// Shared types and constants for the touch point poller.
package itp_pkg;

  // Number of point bytes read in the second bus read.
  localparam int unsigned POINT_BYTES = 4;

  // Controller register numbers and field masks.
  localparam logic [7:0] REG_FINGERS = 8'h02;
  localparam logic [7:0] REG_POINTS  = 8'h03;
  localparam logic [3:0] FINGER_MASK = 4'hF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_HALF_PERIOD  = 3'd0,
    CFG_ACK_TIMEOUT  = 3'd1,
    CFG_DEV_ADDR     = 3'd2,
    CFG_MAX_FINGERS  = 3'd3,
    CFG_SCREEN_W     = 3'd4,
    CFG_SCREEN_H     = 3'd5,
    CFG_SWAP_AXES    = 3'd6
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_HALF_PERIOD = 16'd280;
  localparam logic [9:0]  RST_ACK_TIMEOUT = 10'd250;
  localparam logic [6:0]  RST_DEV_ADDR    = 7'd21;
  localparam logic [3:0]  RST_MAX_FINGERS = 4'd2;
  localparam logic [11:0] RST_SCREEN_W    = 12'd480;
  localparam logic [11:0] RST_SCREEN_H    = 12'd854;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [9:0]  ack_timeout_limit;
    logic [6:0]  device_address;
    logic [3:0]  max_finger_count;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic        swap_axes;
  } cfg_t;

  // Point bytes captured from the controller, entry 0 first.
  typedef logic [POINT_BYTES-1:0][7:0] point_bytes_t;

  // Touch report formed from the point bytes.
  typedef struct packed {
    logic        pressed;
    logic [3:0]  finger_count;
    logic [11:0] x_position;
    logic [11:0] y_position;
  } touch_t;

  // One result item.
  typedef struct packed {
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        bus_error;
    touch_t      touch;
  } result_t;

endpackage

/* hdl/itp_ifs.sv */
// Channel interfaces: tick input, result output and configuration write.
interface itp_tick_if;
  logic valid;
  logic ready;
  logic kind;
  logic sda_sample;

  modport source(output valid, kind, sda_sample, input ready);
  modport sink(input valid, kind, sda_sample, output ready);
endinterface

interface itp_res_if;
  logic        valid;
  logic        ready;
  logic        scl_level;
  logic        sda_pull_low;
  logic        busy_res;
  logic        done_res;
  logic        bus_error;
  logic        pressed;
  logic [3:0]  finger_count;
  logic [11:0] x_position;
  logic [11:0] y_position;

  modport source(output valid, scl_level, sda_pull_low, busy_res, done_res, bus_error,
                 pressed, finger_count, x_position, y_position, input ready);
  modport sink(input valid, scl_level, sda_pull_low, busy_res, done_res, bus_error,
               pressed, finger_count, x_position, y_position, output ready);
endinterface

interface itp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hdl/i2c_touch_point_poller.sv */
// Top level of the touch point poller: channels, result register and checks.
//
// The tick channel carries one bus timing tick per transaction: the sampled SDA
// level and a poll request flag. Every accepted tick yields exactly one result
// transaction with the SCL level, the SDA pull-down, the busy flag and, on the
// tick a poll ends, the done flag, the error flag and the touch report.
// A poll reads the finger-count register and, for a valid count, the four
// point bytes; each bus half period is timed by the configured tick count.
// The sequencer settles one tick combinationally, so a tick is taken every cycle
// unless stalled, and its result enters the result register in the cycle after
// it is accepted. The result register is the only storage between the two sides.
// When the receiver stalls, the pending result holds and new ticks are taken
// again in the same cycle that it is taken. The configuration channel is always
// ready; the user must write registers only while no poll is in progress; the
// block does not enforce it. Reset returns the sequencer to idle with SCL
// released, empties the result register and loads the default configuration.
module i2c_touch_point_poller (
  input  logic       clk,
  input  logic       rst,
  itp_tick_if.sink   tick,
  itp_res_if.source  res,
  itp_cfg_if.sink    cfg
);
  import itp_pkg::*;

  cfg_t    cfg_q;
  result_t seq_result;
  result_t res_q;
  logic    res_valid;
  logic    tick_accept;

  assign tick.ready  = !res_valid || res.ready;
  assign tick_accept = tick.valid && tick.ready;

  itp_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  itp_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .en         (tick_accept),
    .kind       (tick.kind),
    .sda_sample (tick.sda_sample),
    .cfg_q      (cfg_q),
    .result     (seq_result)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (tick_accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload loads with each accepted tick.
  always_ff @(posedge clk) begin
    if (tick_accept) begin
      res_q <= seq_result;
    end
  end

  assign res.valid        = res_valid;
  assign res.scl_level    = res_q.scl_level;
  assign res.sda_pull_low = res_q.sda_pull_low;
  assign res.busy_res     = res_q.busy_res;
  assign res.done_res     = res_q.done_res;
  assign res.bus_error    = res_q.bus_error;
  assign res.pressed      = res_q.touch.pressed;
  assign res.finger_count = res_q.touch.finger_count;
  assign res.x_position   = res_q.touch.x_position;
  assign res.y_position   = res_q.touch.y_position;

  // Every accepted tick leaves a pending result.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    tick_accept |=> res_valid)
    else $error("accepted tick left no result");

  // A stalled result blocks the tick channel.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ready) |-> !tick.ready)
    else $error("tick taken while result stalled");

  // A finished poll leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.done_res) |-> !res_q.busy_res)
    else $error("done reported while busy");

  // A touch is reported only on a clean finish with a finger.
  a_pressed_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.touch.pressed) |->
      (res_q.done_res && !res_q.bus_error && res_q.touch.finger_count != 4'd0))
    else $error("touch reported without a clean finish");

endmodule

/* hdl/itp_cfg_regs.sv */
// Configuration register bank written through the configuration channel.
module itp_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  itp_cfg_if.sink         cfg,
  output itp_pkg::cfg_t   cfg_q
);
  import itp_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register file with reset defaults; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.half_period_ticks <= RST_HALF_PERIOD;
      cfg_q.ack_timeout_limit <= RST_ACK_TIMEOUT;
      cfg_q.device_address    <= RST_DEV_ADDR;
      cfg_q.max_finger_count  <= RST_MAX_FINGERS;
      cfg_q.screen_width      <= RST_SCREEN_W;
      cfg_q.screen_height     <= RST_SCREEN_H;
      cfg_q.swap_axes         <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg.data;
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout_limit <= cfg.data[9:0];
        CFG_DEV_ADDR:    cfg_q.device_address    <= cfg.data[6:0];
        CFG_MAX_FINGERS: cfg_q.max_finger_count  <= cfg.data[3:0];
        CFG_SCREEN_W:    cfg_q.screen_width      <= cfg.data[11:0];
        CFG_SCREEN_H:    cfg_q.screen_height     <= cfg.data[11:0];
        CFG_SWAP_AXES:   cfg_q.swap_axes         <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* hdl/itp_coord.sv */
// Forms the touch report from the captured point bytes and the screen bounds.
module itp_coord (
  input  itp_pkg::point_bytes_t point_bytes,
  input  logic [3:0]            fingers_read,
  input  itp_pkg::cfg_t         cfg_q,
  output itp_pkg::touch_t       touch
);
  import itp_pkg::*;

  logic [11:0] raw_x;
  logic [11:0] raw_y;
  logic [11:0] px;
  logic [11:0] py;
  logic        in_bounds;

  // Twelve-bit coordinates from high nibble and low byte pairs.
  assign raw_x = {point_bytes[0][3:0], point_bytes[1]};
  assign raw_y = {point_bytes[2][3:0], point_bytes[3]};

  // Landscape mode exchanges the axes before the bounds check.
  assign px = cfg_q.swap_axes ? raw_y : raw_x;
  assign py = cfg_q.swap_axes ? raw_x : raw_y;

  assign in_bounds = (px < cfg_q.screen_width) && (py < cfg_q.screen_height) &&
                     (fingers_read != 4'd0);

  // A rejected touch reports all zeros.
  always_comb begin
    touch = '0;
    if (in_bounds) begin
      touch.pressed      = 1'b1;
      touch.finger_count = fingers_read;
      touch.x_position   = px;
      touch.y_position   = py;
    end
  end

endmodule

/* hdl/itp_seq.sv */
// Bus sequencer: advances the bit-banged register reads by one tick per accepted item.
module itp_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              kind,
  input  logic              sda_sample,
  input  itp_pkg::cfg_t     cfg_q,
  output itp_pkg::result_t  result
);
  import itp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START_A   = 5'd1,
    ST_START_B   = 5'd2,
    ST_START_C   = 5'd3,
    ST_TX_BIT    = 5'd4,
    ST_TX_HIGH   = 5'd5,
    ST_TX_LOW    = 5'd6,
    ST_ACK_A     = 5'd7,
    ST_ACK_POLL  = 5'd8,
    ST_RX_LOW    = 5'd9,
    ST_RX_HIGH   = 5'd10,
    ST_RX_SAMPLE = 5'd11,
    ST_MACK_A    = 5'd12,
    ST_MACK_B    = 5'd13,
    ST_MACK_C    = 5'd14,
    ST_STOP_A    = 5'd15,
    ST_STOP_B    = 5'd16,
    ST_STOP_C    = 5'd17,
    ST_ESTOP_A   = 5'd18,
    ST_ESTOP_B   = 5'd19,
    ST_ESTOP_C   = 5'd20
  } step_t;

  localparam logic [3:0] LEN_POINTS  = 4'(POINT_BYTES);
  localparam logic [3:0] LEN_FINGERS = 4'd1;

  // Sequencer state; stage_b marks the point-byte read.
  step_t        step, step_next;
  logic         stage_b, stage_b_next;
  logic [15:0]  delay_count, delay_count_next;
  logic [9:0]   wait_count, wait_count_next;
  logic [3:0]   bit_count, bit_count_next;
  logic [7:0]   shift_byte, shift_byte_next;
  logic [2:0]   byte_index, byte_index_next;
  logic [3:0]   fingers_read, fingers_read_next;
  logic         scl_reg, scl_reg_next;
  logic         sda_reg, sda_reg_next;
  point_bytes_t point_bytes;

  logic         pb_we;
  logic [1:0]   pb_addr;
  logic [7:0]   pb_data;
  logic         done, err;
  logic         use_touch;
  logic [3:0]   len;
  logic [3:0]   finger_raw;
  touch_t       touch;

  // Byte to transmit for the current byte of the read sequence.
  function automatic logic [7:0] tx_byte(input logic [2:0] idx, input logic stb,
                                         input logic [6:0] addr);
    logic [7:0] res;
    if (idx == 3'd0) begin
      res = {addr, 1'b0};
    end else if (idx == 3'd1) begin
      res = stb ? REG_POINTS : REG_FINGERS;
    end else begin
      res = {addr, 1'b1};
    end
    return res;
  endfunction

  itp_coord u_coord (
    .point_bytes  (point_bytes),
    .fingers_read (fingers_read),
    .cfg_q        (cfg_q),
    .touch        (touch)
  );

  // Next-state logic for one tick.
  always_comb begin
    step_next         = step;
    stage_b_next      = stage_b;
    delay_count_next  = delay_count;
    wait_count_next   = wait_count;
    bit_count_next    = bit_count;
    shift_byte_next   = shift_byte;
    byte_index_next   = byte_index;
    fingers_read_next = fingers_read;
    scl_reg_next      = scl_reg;
    sda_reg_next      = sda_reg;
    pb_we             = 1'b0;
    pb_addr           = byte_index[1:0];
    pb_data           = 8'd0;
    done              = 1'b0;
    err               = 1'b0;
    use_touch         = 1'b0;
    finger_raw        = 4'd0;

    // A poll request while idle starts the finger-count read.
    if (!stage_b && step == ST_IDLE && kind) begin
      step_next         = ST_START_A;
      byte_index_next   = 3'd0;
      fingers_read_next = 4'd0;
      delay_count_next  = 16'd0;
    end

    len = stage_b_next ? LEN_POINTS : LEN_FINGERS;

    if (stage_b_next || step_next != ST_IDLE) begin
      if (delay_count_next != 16'd0) begin
        delay_count_next = delay_count_next - 16'd1;
      end else begin
        case (step_next)
          ST_START_A: begin
            sda_reg_next     = 1'b0;
            scl_reg_next     = 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_START_B;
          end
          ST_START_B: begin
            sda_reg_next     = 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_START_C;
          end
          ST_START_C: begin
            scl_reg_next    = 1'b0;
            shift_byte_next = tx_byte(byte_index_next, stage_b_next, cfg_q.device_address);
            bit_count_next  = 4'd0;
            step_next       = ST_TX_BIT;
          end
          ST_TX_BIT: begin
            sda_reg_next     = ~shift_byte_next[7];
            shift_byte_next  = {shift_byte_next[6:0], 1'b0};
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_TX_HIGH;
          end
          ST_TX_HIGH: begin
            scl_reg_next     = 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_TX_LOW;
          end
          ST_TX_LOW: begin
            scl_reg_next   = 1'b0;
            bit_count_next = bit_count_next + 4'd1;
            step_next      = (bit_count_next >= 4'd8) ? ST_ACK_A : ST_TX_BIT;
          end
          ST_ACK_A: begin
            sda_reg_next     = 1'b0;
            scl_reg_next     = 1'b1;
            wait_count_next  = 10'd0;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_ACK_POLL;
          end
          ST_ACK_POLL: begin
            if (sda_sample) begin
              // Still no acknowledge: count the sample or give up.
              if (wait_count_next >= cfg_q.ack_timeout_limit) begin
                step_next = ST_ESTOP_A;
              end else begin
                wait_count_next  = wait_count_next + 10'd1;
                delay_count_next = cfg_q.half_period_ticks;
              end
            end else begin
              scl_reg_next = 1'b0;
              if (byte_index_next == 3'd0) begin
                byte_index_next = 3'd1;
                shift_byte_next = tx_byte(3'd1, stage_b_next, cfg_q.device_address);
                bit_count_next  = 4'd0;
                step_next       = ST_TX_BIT;
              end else if (byte_index_next == 3'd1) begin
                byte_index_next = 3'd2;
                step_next       = ST_START_A;
              end else begin
                byte_index_next = 3'd0;
                bit_count_next  = 4'd0;
                shift_byte_next = 8'd0;
                step_next       = ST_RX_LOW;
              end
            end
          end
          ST_RX_LOW: begin
            scl_reg_next     = 1'b0;
            sda_reg_next     = 1'b0;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_RX_HIGH;
          end
          ST_RX_HIGH: begin
            scl_reg_next     = 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_RX_SAMPLE;
          end
          ST_RX_SAMPLE: begin
            shift_byte_next = {shift_byte_next[6:0], sda_sample};
            bit_count_next  = bit_count_next + 4'd1;
            if (bit_count_next >= 4'd8) begin
              if (!stage_b_next) begin
                // Finger count outside one to the limit counts as no touch.
                finger_raw = shift_byte_next[3:0] & FINGER_MASK;
                fingers_read_next = (finger_raw != 4'd0 &&
                                     finger_raw <= cfg_q.max_finger_count) ? finger_raw : 4'd0;
              end else if ({1'b0, byte_index_next} < LEN_POINTS) begin
                pb_we   = 1'b1;
                pb_addr = byte_index_next[1:0];
                pb_data = shift_byte_next;
              end
              step_next = ST_MACK_A;
            end else begin
              step_next = ST_RX_LOW;
            end
          end
          ST_MACK_A: begin
            // Acknowledge every byte but the last one.
            scl_reg_next     = 1'b0;
            sda_reg_next     = (({1'b0, byte_index_next} + 4'd1) >= len) ? 1'b0 : 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_MACK_B;
          end
          ST_MACK_B: begin
            scl_reg_next     = 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_MACK_C;
          end
          ST_MACK_C: begin
            scl_reg_next    = 1'b0;
            byte_index_next = byte_index_next + 3'd1;
            if ({1'b0, byte_index_next} >= len) begin
              step_next = ST_STOP_A;
            end else begin
              bit_count_next  = 4'd0;
              shift_byte_next = 8'd0;
              step_next       = ST_RX_LOW;
            end
          end
          ST_STOP_A: begin
            scl_reg_next     = 1'b0;
            sda_reg_next     = 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_STOP_B;
          end
          ST_ESTOP_A: begin
            scl_reg_next     = 1'b0;
            sda_reg_next     = 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_ESTOP_B;
          end
          ST_STOP_B: begin
            scl_reg_next     = 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_STOP_C;
          end
          ST_ESTOP_B: begin
            scl_reg_next     = 1'b1;
            delay_count_next = cfg_q.half_period_ticks;
            step_next        = ST_ESTOP_C;
          end
          ST_STOP_C: begin
            sda_reg_next = 1'b0;
            if (!stage_b_next && fingers_read_next != 4'd0) begin
              // A valid count goes on to the point-byte read.
              stage_b_next    = 1'b1;
              step_next       = ST_START_A;
              byte_index_next = 3'd0;
            end else begin
              use_touch    = stage_b_next;
              stage_b_next = 1'b0;
              step_next    = ST_IDLE;
              done         = 1'b1;
            end
          end
          ST_ESTOP_C: begin
            sda_reg_next = 1'b0;
            stage_b_next = 1'b0;
            step_next    = ST_IDLE;
            done         = 1'b1;
            err          = 1'b1;
          end
          default: begin
            stage_b_next = 1'b0;
            step_next    = ST_IDLE;
            scl_reg_next = 1'b1;
            sda_reg_next = 1'b0;
          end
        endcase
      end
    end
  end

  // Result of this tick.
  always_comb begin
    result.scl_level    = scl_reg_next;
    result.sda_pull_low = sda_reg_next;
    result.busy_res     = stage_b_next || (step_next != ST_IDLE);
    result.done_res     = done;
    result.bus_error    = err;
    result.touch        = use_touch ? touch : '0;
  end

  // Control state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      stage_b      <= 1'b0;
      delay_count  <= 16'd0;
      wait_count   <= 10'd0;
      bit_count    <= 4'd0;
      shift_byte   <= 8'd0;
      byte_index   <= 3'd0;
      fingers_read <= 4'd0;
      scl_reg      <= 1'b1;
      sda_reg      <= 1'b0;
    end else if (en) begin
      step         <= step_next;
      stage_b      <= stage_b_next;
      delay_count  <= delay_count_next;
      wait_count   <= wait_count_next;
      bit_count    <= bit_count_next;
      shift_byte   <= shift_byte_next;
      byte_index   <= byte_index_next;
      fingers_read <= fingers_read_next;
      scl_reg      <= scl_reg_next;
      sda_reg      <= sda_reg_next;
    end
  end

  // Point bytes hold payload only and are always written before use.
  always_ff @(posedge clk) begin
    if (en && pb_we) begin
      point_bytes[pb_addr] <= pb_data;
    end
  end

endmodule
